/* rtl/core/mrs_pkg.sv */
// mrs_pkg: shared constants, types and the register default table for the
// modbus rtu register slave; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mrs_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [15:0] word_type;

   localparam word_type CRC_INIT   = 16'hFFFF;
   localparam word_type CRC_POLY   = 16'hA001;
   localparam byte_type FUNC_READ  = 8'h03;
   localparam byte_type FUNC_WRITE = 8'h06;
   localparam byte_type BASE_RESET = 8'h01;

   localparam word_type DEFAULT_TABLE [16][4] = '{
      '{16'h007B, 16'hFFBE, 16'h2211, 16'h0022},
      '{16'h0033, 16'h0022, 16'h0003, 16'h0004},
      '{16'h0003, 16'h0002, 16'h0003, 16'h0004},
      '{16'h0004, 16'h0002, 16'h0003, 16'h0004},
      '{16'h0005, 16'h0002, 16'h0003, 16'h0004},
      '{16'h0006, 16'h0002, 16'h0003, 16'h0004},
      '{16'h0007, 16'h0002, 16'h0003, 16'h0004},
      '{16'h0008, 16'h0002, 16'h0003, 16'h0004},
      '{16'h0009, 16'h0002, 16'h0003, 16'h0004},
      '{16'h000A, 16'h0002, 16'h0003, 16'h0004},
      '{16'h000B, 16'h0002, 16'h0003, 16'h0004},
      '{16'h000C, 16'h0002, 16'h0003, 16'h0004},
      '{16'h000D, 16'h0002, 16'h0003, 16'h0004},
      '{16'h000E, 16'h0002, 16'h0003, 16'h0085},
      '{16'h000F, 16'h0002, 16'h0003, 16'h0004},
      '{16'h0010, 16'h0002, 16'h0003, 16'h0004}
   };

   // columns beyond the table reset to zero
   function automatic word_type default_word(input logic [3:0] ch, input logic [3:0] r);
      word_type w;
      w = 16'h0000;
      if (r < 4'd4) begin
         w = DEFAULT_TABLE[ch][r[1:0]];
      end
      return w;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/mrs_ram.sv */
// mrs_ram: generic single-port ram, one write or read per cycle, registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module mrs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    addr,
   input  wire logic [WIDTH-1:0] wr_data,
   output      logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end

endmodule

`default_nettype wire

/* rtl/core/modbus_rtu_register_slave_unit.sv */
// modbus_rtu_register_slave_unit: modbus rtu slave for functions 03 and 06
// depends on mrs_pkg and mrs_ram
//
// channel  | handshake                          | payload
// request  | start in, busy out                 | req_in_channel, req_rx_byte, req_frame_end
// response | rsp_strobe out, one cycle per byte | rsp_out_channel, rsp_tx_byte, rsp_tx_last
// config   | apb psel/penable/pwrite, pready=1  | paddr, pwdata, prdata (address_base at 0)
//
// a byte of a frame is taken in idle alone while fewer than two bytes are held, else
// it also runs 8 steps of the shared crc shifter. a final byte adds the check state;
// each reply data byte then runs 8 shifter steps, a register first passes S_RDADDR and
// S_RDDATA, and the two crc bytes need no shifter steps. synchronous reset restores the
// store to its default table at once through per-entry valid bits. replies cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module modbus_rtu_register_slave_unit #(
   parameter int CHANNELS         = 16,
   parameter int REGS_PER_CHANNEL = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output      logic        busy,
   input  wire logic [3:0]  req_in_channel,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic        req_frame_end,
   output      logic        rsp_strobe,
   output      logic [3:0]  rsp_out_channel,
   output      logic [7:0]  rsp_tx_byte,
   output      logic        rsp_tx_last,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output      logic [31:0] prdata,
   output      logic        pready
);

   localparam int DEPTH = CHANNELS * REGS_PER_CHANNEL;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RIW   = (REGS_PER_CHANNEL > 1) ? $clog2(REGS_PER_CHANNEL) : 1;
   localparam int CNTW  = $clog2(REGS_PER_CHANNEL + 1);
   localparam logic [AW-1:0] REGS_A  = AW'(REGS_PER_CHANNEL);
   localparam logic [15:0]   REGS_16 = 16'(REGS_PER_CHANNEL);
   localparam logic [4:0]    CH_LIM  = 5'(CHANNELS);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_RXSHIFT = 4'd1;
   localparam logic [3:0] S_CHECK   = 4'd2;
   localparam logic [3:0] S_HDR     = 4'd3;
   localparam logic [3:0] S_TXSHIFT = 4'd4;
   localparam logic [3:0] S_RDADDR  = 4'd5;
   localparam logic [3:0] S_RDDATA  = 4'd6;
   localparam logic [3:0] S_REG     = 4'd7;
   localparam logic [3:0] S_CRCLO   = 4'd8;
   localparam logic [3:0] S_CRCHI   = 4'd9;

   logic [3:0]             state_ff, state_in;
   logic [7:0]             base_ff;
   logic [7:0]             len_ff, len_in;
   logic [15:0]            tail_ff, tail_in;
   mrs_pkg::word_type      crc_ff, crc_in;
   logic [3:0]             fch_ff, fch_in;
   mrs_pkg::byte_type      hdr_ff [6];
   logic                   end_ff, end_in;
   logic [2:0]             bit_ff, bit_in;
   logic                   wr06_ff, wr06_in;
   logic [2:0]             hidx_ff, hidx_in;
   logic                   phase_ff, phase_in;
   logic [RIW-1:0]         ridx_ff, ridx_in;
   logic [CNTW-1:0]        rcnt_ff, rcnt_in;
   mrs_pkg::word_type      word_ff, word_in;
   logic                   lo_ff, lo_in;
   logic [DEPTH-1:0]       vld_ff;
   logic                   vldq_ff, vldq_in;
   logic                   strobe_in, last_in;
   mrs_pkg::byte_type      byte_in;

   mrs_pkg::word_type      crc_step;
   mrs_pkg::byte_type      station;
   logic [15:0]            a16, v16, avail;
   logic                   a_ok, frame_ok, is_write;
   logic [CNTW-1:0]        cnt03;
   mrs_pkg::byte_type      hdr_byte, reg_byte;
   logic                   ram_we;
   logic [AW-1:0]          ram_addr, ram_base;
   mrs_pkg::word_type      ram_q;
   logic                   csr_wr;

   assign busy     = (state_ff != S_IDLE);
   assign pready   = 1'b1;
   assign csr_wr   = psel && penable && pwrite && pready && !paddr[2];
   assign prdata   = paddr[2] ? 32'h0 : {24'h0, base_ff};

   // shared crc shifter, one bit per cycle
   assign crc_step = crc_ff[0] ? ((crc_ff >> 1) ^ mrs_pkg::CRC_POLY) : (crc_ff >> 1);

   assign station  = base_ff + {4'h0, fch_ff};
   assign a16      = {hdr_ff[2], hdr_ff[3]};
   assign v16      = {hdr_ff[4], hdr_ff[5]};
   assign a_ok     = (a16 < REGS_16);
   assign avail    = REGS_16 - a16;
   assign cnt03    = !a_ok ? '0 : ((v16 < avail) ? v16[CNTW-1:0] : avail[CNTW-1:0]);
   assign is_write = (hdr_ff[1] == mrs_pkg::FUNC_WRITE);
   assign frame_ok = (len_ff >= 8'd6) && ({1'b0, fch_ff} < CH_LIM)
                     && (hdr_ff[0] == station) && (tail_ff == crc_ff)
                     && ((hdr_ff[1] == mrs_pkg::FUNC_READ) || is_write);

   assign ram_base = AW'(fch_ff) * REGS_A;
   assign ram_we   = (state_ff == S_CHECK) && frame_ok && is_write && a_ok;
   assign ram_addr = (state_ff == S_CHECK) ? (ram_base + AW'(a16[RIW-1:0]))
                                           : (ram_base + AW'(ridx_ff));

   mrs_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (v16),
      .rd_data (ram_q)
   );

   always_comb begin
      case (hidx_ff)
         3'd0:    hdr_byte = station;
         3'd1:    hdr_byte = hdr_ff[1];
         3'd2:    hdr_byte = wr06_ff ? hdr_ff[2] : {hdr_ff[5][6:0], 1'b0};
         3'd3:    hdr_byte = hdr_ff[3];
         3'd4:    hdr_byte = hdr_ff[4];
         default: hdr_byte = hdr_ff[5];
      endcase
      reg_byte = lo_ff ? word_ff[7:0] : word_ff[15:8];
   end

   always_comb begin
      state_in  = state_ff;
      len_in    = len_ff;
      tail_in   = tail_ff;
      crc_in    = crc_ff;
      fch_in    = fch_ff;
      end_in    = end_ff;
      bit_in    = bit_ff;
      wr06_in   = wr06_ff;
      hidx_in   = hidx_ff;
      phase_in  = phase_ff;
      ridx_in   = ridx_ff;
      rcnt_in   = rcnt_ff;
      word_in   = word_ff;
      lo_in     = lo_ff;
      vldq_in   = vldq_ff;
      strobe_in = 1'b0;
      last_in   = 1'b0;
      byte_in   = crc_ff[7:0];
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (len_ff == 8'd0) begin
                  fch_in = req_in_channel;
               end
               tail_in = {req_rx_byte, tail_ff[15:8]};
               if (len_ff != 8'hFF) begin
                  len_in = len_ff + 8'd1;
               end
               end_in = req_frame_end;
               if (len_ff >= 8'd2) begin
                  crc_in   = crc_ff ^ {8'h00, tail_ff[7:0]};
                  bit_in   = 3'd0;
                  state_in = S_RXSHIFT;
               end else if (req_frame_end) begin
                  state_in = S_CHECK;
               end
            end
         end
         S_RXSHIFT: begin
            crc_in = crc_step;
            bit_in = bit_ff + 3'd1;
            if (bit_ff == 3'd7) begin
               state_in = end_ff ? S_CHECK : S_IDLE;
            end
         end
         S_CHECK: begin
            len_in   = 8'd0;
            tail_in  = 16'h0000;
            crc_in   = mrs_pkg::CRC_INIT;
            wr06_in  = is_write;
            hidx_in  = 3'd0;
            phase_in = 1'b0;
            lo_in    = 1'b0;
            ridx_in  = a16[RIW-1:0];
            rcnt_in  = is_write ? '0 : cnt03;
            state_in = frame_ok ? S_HDR : S_IDLE;
         end
         S_HDR: begin
            strobe_in = 1'b1;
            byte_in   = hdr_byte;
            crc_in    = crc_ff ^ {8'h00, hdr_byte};
            bit_in    = 3'd0;
            state_in  = S_TXSHIFT;
         end
         S_TXSHIFT: begin
            crc_in = crc_step;
            bit_in = bit_ff + 3'd1;
            if (bit_ff == 3'd7) begin
               if (!phase_ff) begin
                  if (hidx_ff != (wr06_ff ? 3'd5 : 3'd2)) begin
                     hidx_in  = hidx_ff + 3'd1;
                     state_in = S_HDR;
                  end else begin
                     phase_in = 1'b1;
                     state_in = (rcnt_ff != '0) ? S_RDADDR : S_CRCLO;
                  end
               end else if (!lo_ff) begin
                  lo_in    = 1'b1;
                  state_in = S_REG;
               end else begin
                  lo_in    = 1'b0;
                  ridx_in  = ridx_ff + 1'b1;
                  rcnt_in  = rcnt_ff - 1'b1;
                  state_in = (rcnt_ff != CNTW'(1)) ? S_RDADDR : S_CRCLO;
               end
            end
         end
         S_RDADDR: begin
            vldq_in  = vld_ff[ram_addr];
            state_in = S_RDDATA;
         end
         S_RDDATA: begin
            word_in  = vldq_ff ? ram_q : mrs_pkg::default_word(fch_ff, 4'(ridx_ff));
            state_in = S_REG;
         end
         S_REG: begin
            strobe_in = 1'b1;
            byte_in   = reg_byte;
            crc_in    = crc_ff ^ {8'h00, reg_byte};
            bit_in    = 3'd0;
            state_in  = S_TXSHIFT;
         end
         S_CRCLO: begin
            strobe_in = 1'b1;
            byte_in   = crc_ff[7:0];
            state_in  = S_CRCHI;
         end
         S_CRCHI: begin
            strobe_in = 1'b1;
            last_in   = 1'b1;
            byte_in   = crc_ff[15:8];
            crc_in    = mrs_pkg::CRC_INIT;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         base_ff    <= mrs_pkg::BASE_RESET;
         len_ff     <= 8'd0;
         tail_ff    <= 16'h0000;
         crc_ff     <= mrs_pkg::CRC_INIT;
         fch_ff     <= 4'd0;
         end_ff     <= 1'b0;
         vld_ff     <= '0;
         rsp_strobe <= 1'b0;
      end else begin
         state_ff   <= state_in;
         len_ff     <= len_in;
         tail_ff    <= tail_in;
         crc_ff     <= crc_in;
         fch_ff     <= fch_in;
         end_ff     <= end_in;
         rsp_strobe <= strobe_in;
         if (csr_wr) begin
            base_ff <= pwdata[7:0];
         end
         if (ram_we) begin
            vld_ff[ram_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_IDLE) && start && (len_ff < 8'd6)) begin
         hdr_ff[len_ff[2:0]] <= req_rx_byte;
      end
      bit_ff          <= bit_in;
      wr06_ff         <= wr06_in;
      hidx_ff         <= hidx_in;
      phase_ff        <= phase_in;
      ridx_ff         <= ridx_in;
      rcnt_ff         <= rcnt_in;
      word_ff         <= word_in;
      lo_ff           <= lo_in;
      vldq_ff         <= vldq_in;
      rsp_tx_byte     <= byte_in;
      rsp_tx_last     <= last_in;
      rsp_out_channel <= fch_ff;
   end

endmodule

`default_nettype wire

/* rtl/core/mrs_checker.sv */
// mrs_checker: port-level assertions for modbus_rtu_register_slave_unit
// bound to the top level; no other dependencies
`timescale 1ns / 1ps
`default_nettype none

module mrs_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic req_frame_end,
   input wire logic rsp_strobe,
   input wire logic rsp_tx_last
);

   // a byte that does not end a frame produces no reply byte
   a_no_reply_mid_frame: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_frame_end) |=> !rsp_strobe)
      else $error("reply byte after non-final request transaction");

   // the block stays busy while a reply is still being sent
   a_busy_mid_reply: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_tx_last) |-> busy)
      else $error("idle in the middle of a reply");

   // the final reply byte returns the block to idle
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_tx_last) |-> !busy)
      else $error("still busy at final reply byte");

   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_tx_last) |=> !rsp_strobe)
      else $error("reply byte right after final reply byte");

endmodule

bind modbus_rtu_register_slave_unit mrs_checker u_mrs_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_frame_end (req_frame_end),
   .rsp_strobe    (rsp_strobe),
   .rsp_tx_last   (rsp_tx_last)
);

`default_nettype wire

/* tb/mrs_reply_checker.sv */
`timescale 1ns / 1ps
// mrs_reply_checker: watches the request, reply and register ports of the modbus rtu
// register slave, predicts every reply byte and compares it with the one sent
// depends on mrs_pkg for the crc constants, function codes and the register default table

module mrs_reply_checker #(
   parameter int         CHANNELS          = 16,
   parameter int         REGS_PER_CHANNEL  = 4,
   parameter logic [2:0] STATION_BASE_ADDR = 3'd0
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic [3:0]  req_in_channel,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic        req_frame_end,
   input  wire logic        rsp_strobe,
   input  wire logic [3:0]  rsp_out_channel,
   input  wire logic [7:0]  rsp_tx_byte,
   input  wire logic        rsp_tx_last,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   input  wire logic [31:0] prdata,
   input  wire logic        pready,
   output int               fail_count,
   output int               pending_count
);

   localparam int REPLY_MAX = 3 + 2 * REGS_PER_CHANNEL + 2;

   typedef struct packed {
      logic [3:0]        channel;
      mrs_pkg::byte_type data;
      logic              last;
   } tx_beat_type;

   tx_beat_type       expected_tx [$];
   tx_beat_type       head;
   mrs_pkg::word_type reg_file [CHANNELS][REGS_PER_CHANNEL];
   mrs_pkg::byte_type station_base;
   logic [7:0]        frame_len;
   mrs_pkg::byte_type hdr [6];
   mrs_pkg::word_type tail;
   mrs_pkg::word_type crc_acc;
   logic [3:0]        frame_ch;
   int                failures = 0;

   function automatic mrs_pkg::word_type crc_step(input mrs_pkg::word_type c,
                                                 input mrs_pkg::byte_type b);
      mrs_pkg::word_type x;
      x = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         x = x[0] ? ((x >> 1) ^ mrs_pkg::CRC_POLY) : (x >> 1);
      end
      return x;
   endfunction

   task automatic clear_frame();
      frame_len = 8'd0;
      tail = 16'h0000;
      crc_acc = mrs_pkg::CRC_INIT;
   endtask

   task automatic reset_model();
      station_base = mrs_pkg::BASE_RESET;
      for (int c = 0; c < CHANNELS; c++) begin
         for (int r = 0; r < REGS_PER_CHANNEL; r++) begin
            reg_file[c][r] = (r < 4) ? mrs_pkg::DEFAULT_TABLE[c % 16][r] : 16'h0000;
         end
      end
      for (int k = 0; k < 6; k++) begin
         hdr[k] = 8'h00;
      end
      frame_ch = 4'h0;
      clear_frame();
      expected_tx.delete();
   endtask

   task automatic note_failure(input string what);
      failures++;
      if (failures <= 10) begin
         $display("%0t ns: %s", $time, what);
      end
   endtask

   // crc runs two bytes behind the stream; the last two bytes are the received crc
   task automatic predict_reply(input logic [3:0] ch, input mrs_pkg::byte_type b,
                                input logic last);
      mrs_pkg::byte_type msg [REPLY_MAX];
      int                n;
      int unsigned       len;
      int unsigned       stop;
      logic [3:0]        fch;
      mrs_pkg::word_type calc;
      mrs_pkg::word_type recv;
      mrs_pkg::word_type a;
      mrs_pkg::word_type v;
      mrs_pkg::word_type c;
      mrs_pkg::byte_type st;
      tx_beat_type       beat;
      if (frame_len == 8'd0) frame_ch = ch;
      if (frame_len >= 8'd2) crc_acc = crc_step(crc_acc, tail[7:0]);
      tail = {b, tail[15:8]};
      if (frame_len < 8'd6) hdr[frame_len] = b;
      if (frame_len != 8'hFF) frame_len = frame_len + 8'd1;
      if (!last) return;

      len = frame_len;
      fch = frame_ch;
      calc = crc_acc;
      recv = tail;
      clear_frame();
      st = station_base + {4'h0, fch};
      if (len < 4 || fch >= CHANNELS) return;
      if (hdr[0] != st || recv != calc) return;
      if (hdr[1] != mrs_pkg::FUNC_READ && hdr[1] != mrs_pkg::FUNC_WRITE) return;
      if (len < 6) return;

      a = {hdr[2], hdr[3]};
      v = {hdr[4], hdr[5]};
      msg[0] = st;
      if (hdr[1] == mrs_pkg::FUNC_READ) begin
         msg[1] = mrs_pkg::FUNC_READ;
         msg[2] = {v[6:0], 1'b0};
         n = 3;
         stop = 32'(a) + 32'(v);
         for (int unsigned r = a; r < stop && r < REGS_PER_CHANNEL; r++) begin
            msg[n] = reg_file[fch][r][15:8];
            msg[n + 1] = reg_file[fch][r][7:0];
            n += 2;
         end
      end else begin
         if (a < REGS_PER_CHANNEL) reg_file[fch][int'(a)] = v;
         msg[1] = mrs_pkg::FUNC_WRITE;
         for (int k = 2; k < 6; k++) begin
            msg[k] = hdr[k];
         end
         n = 6;
      end
      c = mrs_pkg::CRC_INIT;
      for (int k = 0; k < n; k++) begin
         c = crc_step(c, msg[k]);
      end
      msg[n] = c[7:0];
      msg[n + 1] = c[15:8];
      n += 2;
      for (int k = 0; k < n; k++) begin
         beat.channel = fch;
         beat.data = msg[k];
         beat.last = (k == n - 1);
         expected_tx.push_back(beat);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         reset_model();
      end else begin
         if (rsp_strobe) begin
            if (expected_tx.size() == 0) begin
               note_failure($sformatf("unexpected reply byte: ch %0d data %02h last %0b",
                  rsp_out_channel, rsp_tx_byte, rsp_tx_last));
            end else begin
               head = expected_tx.pop_front();
               if (rsp_out_channel !== head.channel || rsp_tx_byte !== head.data ||
                   rsp_tx_last !== head.last) begin
                  note_failure($sformatf(
                     "reply byte: expected ch %0d data %02h last %0b, got ch %0d data %02h last %0b",
                     head.channel, head.data, head.last,
                     rsp_out_channel, rsp_tx_byte, rsp_tx_last));
               end
            end
         end
         if (start && !busy) begin
            predict_reply(req_in_channel, req_rx_byte, req_frame_end);
         end
         if (psel && penable && pready && paddr == STATION_BASE_ADDR) begin
            if (pwrite) begin
               station_base = pwdata[7:0];
            end else if (prdata[7:0] !== station_base) begin
               note_failure($sformatf("station base read: expected %02h, got %02h",
                  station_base, prdata[7:0]));
            end
         end
      end
      fail_count <= failures;
      pending_count <= expected_tx.size();
   end

endmodule

/* tb/modbus_rtu_register_slave_unit_tb.sv */
`timescale 1ns / 1ps
// modbus_rtu_register_slave_unit_tb: sends request frames and station base writes into the
// modbus rtu register slave and gives the verdict; depends on mrs_pkg, mrs_reply_checker
// and modbus_rtu_register_slave_unit

module modbus_rtu_register_slave_unit_tb;

   localparam int         CHANNELS          = 16;
   localparam int         REGS_PER_CHANNEL  = 4;
   localparam logic [2:0] ADDR_STATION_BASE = 3'd0;
   localparam logic [2:0] ADDR_UNMAPPED     = 3'd4;
   localparam int         IDLE_PCT          = 23;
   localparam int         PHASE_ITEMS       = 16;
   localparam int         SETTLE_CYCLES     = 24;
   localparam int         TAIL_CYCLES       = 200;
   localparam int         STALL_LIMIT       = 2000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [3:0]  req_in_channel;
   logic [7:0]  req_rx_byte;
   logic        req_frame_end;
   logic        rsp_strobe;
   logic [3:0]  rsp_out_channel;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_tx_last;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;
   int          fail_count;
   int          pending_count;

   mrs_pkg::byte_type frame_q [$];
   mrs_pkg::byte_type base_now;
   int                items_sent = 0;
   bit                gaps_on = 1'b1;
   int                stall_cycles = 0;

   modbus_rtu_register_slave_unit #(
      .CHANNELS         (CHANNELS),
      .REGS_PER_CHANNEL (REGS_PER_CHANNEL)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_in_channel  (req_in_channel),
      .req_rx_byte     (req_rx_byte),
      .req_frame_end   (req_frame_end),
      .rsp_strobe      (rsp_strobe),
      .rsp_out_channel (rsp_out_channel),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_tx_last     (rsp_tx_last),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   mrs_reply_checker #(
      .CHANNELS          (CHANNELS),
      .REGS_PER_CHANNEL  (REGS_PER_CHANNEL),
      .STATION_BASE_ADDR (ADDR_STATION_BASE)
   ) u_chk (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_in_channel  (req_in_channel),
      .req_rx_byte     (req_rx_byte),
      .req_frame_end   (req_frame_end),
      .rsp_strobe      (rsp_strobe),
      .rsp_out_channel (rsp_out_channel),
      .rsp_tx_byte     (rsp_tx_byte),
      .rsp_tx_last     (rsp_tx_last),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready),
      .fail_count      (fail_count),
      .pending_count   (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || psel) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("modbus_rtu_register_slave_unit_tb NOT OK");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   function automatic void append_crc();
      mrs_pkg::word_type c;
      c = mrs_pkg::CRC_INIT;
      foreach (frame_q[i]) begin
         c = c ^ {8'h00, frame_q[i]};
         for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ mrs_pkg::CRC_POLY) : (c >> 1);
         end
      end
      frame_q.push_back(c[7:0]);
      frame_q.push_back(c[15:8]);
   endfunction

   function automatic void build_request(input mrs_pkg::byte_type st,
                                         input mrs_pkg::byte_type fn,
                                         input mrs_pkg::word_type a,
                                         input mrs_pkg::word_type v);
      frame_q.delete();
      frame_q.push_back(st);
      frame_q.push_back(fn);
      frame_q.push_back(a[15:8]);
      frame_q.push_back(a[7:0]);
      frame_q.push_back(v[15:8]);
      frame_q.push_back(v[7:0]);
      append_crc();
   endfunction

   // mostly well-formed 03/06 requests, the rest broken or noise
   function automatic void random_frame(input mrs_pkg::byte_type st);
      int                kind;
      int                len;
      mrs_pkg::byte_type fn;
      mrs_pkg::word_type a;
      mrs_pkg::word_type v;
      kind = $urandom_range(99);
      a = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(5));
      v = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(6));
      fn = $urandom_range(1) ? mrs_pkg::FUNC_READ : mrs_pkg::FUNC_WRITE;
      if (kind < 35) begin
         build_request(st, mrs_pkg::FUNC_READ, a, v);
      end else if (kind < 70) begin
         v = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 16'hFFFF : 16'h0000)
                                      : 16'($urandom);
         build_request(st, mrs_pkg::FUNC_WRITE, a, v);
      end else if (kind < 75) begin
         build_request(st + 8'($urandom_range(1, 255)), fn, a, v);
      end else if (kind < 80) begin
         build_request(st, fn, a, v);
         len = 6 + $urandom_range(1);
         frame_q[len] = frame_q[len] ^ 8'(1 << $urandom_range(7));
      end else if (kind < 85) begin
         do fn = 8'($urandom);
         while (fn == mrs_pkg::FUNC_READ || fn == mrs_pkg::FUNC_WRITE);
         build_request(st, fn, a, v);
      end else if (kind < 93) begin
         len = $urandom_range(1, 5);
         frame_q.delete();
         frame_q.push_back(st);
         if (len >= 2) frame_q.push_back(fn);
         if (len == 3 || len == 5) frame_q.push_back(8'($urandom));
         if (len >= 4) append_crc();
      end else begin
         len = $urandom_range(1, 10);
         frame_q.delete();
         repeat (len) frame_q.push_back(8'($urandom));
      end
   endfunction

   task automatic send_byte(input logic [3:0] ch, input mrs_pkg::byte_type b,
                            input logic last);
      while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_in_channel <= ch;
      req_rx_byte <= b;
      req_frame_end <= last;
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   // with retag set, later bytes may carry other channel tags
   task automatic send_frame(input logic [3:0] ch, input bit retag);
      logic [3:0] tag;
      for (int k = 0; k < frame_q.size(); k++) begin
         tag = (k > 0 && retag && $urandom_range(3) == 0) ? 4'($urandom_range(15)) : ch;
         send_byte(tag, frame_q[k], k == frame_q.size() - 1);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [2:0] addr, input logic [31:0] data,
                             input bit last_one);
      psel <= 1'b1;
      pwrite <= wr;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      penable <= 1'b0;
      if (last_one) begin
         psel <= 1'b0;
         pwrite <= 1'b0;
      end
   endtask

   task automatic set_station_base(input mrs_pkg::byte_type value, input bit poke_unmapped);
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_access(1'b1, ADDR_STATION_BASE, {24'h0, value}, 1'b0);
      if (poke_unmapped) csr_access(1'b1, ADDR_UNMAPPED, $urandom, 1'b0);
      csr_access(1'b0, ADDR_STATION_BASE, 32'h0, 1'b1);
      base_now = value;
   endtask

   initial begin
      int                phase_start;
      bit                paused;
      logic [3:0]        ch;
      mrs_pkg::byte_type next_base;
      paused = 1'b0;
      reset <= 1'b1;
      start <= 1'b0;
      req_in_channel <= 4'h0;
      req_rx_byte <= 8'h00;
      req_frame_end <= 1'b0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= 3'd0;
      pwdata <= 32'h0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: reset base, full read, write with retagged bytes, short frames
      base_now = mrs_pkg::BASE_RESET;
      csr_access(1'b0, ADDR_STATION_BASE, 32'h0, 1'b1);
      build_request(base_now, mrs_pkg::FUNC_READ, 16'h0000, 16'h0004);
      send_frame(4'd0, 1'b0);
      build_request(base_now + 8'd15, mrs_pkg::FUNC_WRITE, 16'h0003, 16'hFFFF);
      send_frame(4'd15, 1'b1);
      frame_q = '{base_now + 8'd7, mrs_pkg::FUNC_READ};
      append_crc();
      send_frame(4'd7, 1'b0);
      frame_q = '{base_now + 8'd9, mrs_pkg::FUNC_WRITE, 8'h00};
      send_frame(4'd9, 1'b0);
      frame_q = '{8'hFF};
      send_frame(4'd4, 1'b0);

      for (int p = 0; p < 4; p++) begin
         next_base = (p == 0) ? 8'd0 : (p == 1) ? 8'd232 : 8'($urandom_range(232));
         set_station_base(next_base, p == 2);
         gaps_on = (p != 3);
         if (p == 3) begin
            // over 255 bytes: length saturates, crc still covers the whole body
            ch = 4'($urandom_range(15));
            build_request(base_now + {4'h0, ch}, mrs_pkg::FUNC_READ, 16'h0000, 16'h0004);
            frame_q = frame_q[0:5];
            repeat (250) frame_q.push_back(8'($urandom));
            append_crc();
            send_frame(ch, 1'b0);
         end
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS) begin
            if (p == 2 && !paused && items_sent - phase_start >= PHASE_ITEMS / 2) begin
               drain();
               paused = 1'b1;
            end
            ch = 4'($urandom_range(15));
            random_frame(base_now + {4'h0, ch});
            send_frame(ch, $urandom_range(4) == 0);
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("modbus_rtu_register_slave_unit_tb OK");
      end else begin
         $display("modbus_rtu_register_slave_unit_tb NOT OK");
      end
      $finish;
   end

endmodule

/* modbus_rtu_register_slave_unit.f */
rtl/core/mrs_pkg.sv
rtl/core/mrs_ram.sv
rtl/core/modbus_rtu_register_slave_unit.sv
rtl/core/mrs_checker.sv
tb/mrs_reply_checker.sv
tb/modbus_rtu_register_slave_unit_tb.sv
